// ----- design/gain_scheduled_pid_controller_top_macros.svh -----
// Assertion macros for the gain-scheduled PID controller.
// Expects clock aclk and active-low reset aresetn in the including module.
`ifndef GAIN_SCHEDULED_PID_CONTROLLER_TOP_MACROS_SVH
`define GAIN_SCHEDULED_PID_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define GSPID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GSPID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gspid_pkg.sv -----
// Shared widths, constants, register indexes and structs of the PID controller.
// No dependencies.
package gspid_pkg;

    localparam int SIG_W    = 24;               // Q12.12 signal
    localparam int GAIN_W   = 32;               // Q16.16 unsigned gain
    localparam int ERR_W    = SIG_W + 1;        // difference of two signals
    localparam int PROD_W   = GAIN_W + ERR_W + 1;
    localparam int FRAC_W   = 16;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = TERM_W + 3;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int CFG_W    = GAIN_W;
    localparam int S_DATA_W = 48;               // two signals, byte aligned
    localparam int M_DATA_W = 24;

    localparam logic [SIG_W-1:0] GAP_THRESHOLD  = 24'd40960;
    localparam logic             REVERSE_ACTION = 1'b0;

    localparam logic [GAIN_W-1:0] RST_CONS_KP = 32'd65536;
    localparam logic [GAIN_W-1:0] RST_CONS_KI = 32'd16;
    localparam logic [GAIN_W-1:0] RST_CONS_KD = 32'd3276800;
    localparam logic [GAIN_W-1:0] RST_AGG_KP  = 32'd262144;
    localparam logic [GAIN_W-1:0] RST_AGG_KI  = 32'd66;
    localparam logic [GAIN_W-1:0] RST_AGG_KD  = 32'd13107200;
    localparam logic [SIG_W-1:0]  RST_LOWER   = 24'd0;
    localparam logic [SIG_W-1:0]  RST_UPPER   = 24'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_CONS_KP = 3'd0,
        REG_CONS_KI = 3'd1,
        REG_CONS_KD = 3'd2,
        REG_AGG_KP  = 3'd3,
        REG_AGG_KI  = 3'd4,
        REG_AGG_KD  = 3'd5,
        REG_LOWER   = 3'd6,
        REG_UPPER   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] cons_kp;
        logic [GAIN_W-1:0] cons_ki;
        logic [GAIN_W-1:0] cons_kd;
        logic [GAIN_W-1:0] agg_kp;
        logic [GAIN_W-1:0] agg_ki;
        logic [GAIN_W-1:0] agg_kd;
        logic [SIG_W-1:0]  out_lower;
        logic [SIG_W-1:0]  out_upper;
    } cfg_t;

    typedef struct packed {
        logic [SIG_W-1:0] drive;
        logic             updated;
        logic             aggressive;
    } result_t;

endpackage

// ----- design/gspid_cfg_regs.sv -----
// Configuration register file: gains and output limits.
// Depends on gspid_pkg.
module gspid_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gspid_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gspid_pkg::CFG_W-1:0]   cfg_wdata,
    output gspid_pkg::cfg_t               cfg
);

    gspid_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                gspid_pkg::REG_CONS_KP: cfg_next.cons_kp = cfg_wdata;
                gspid_pkg::REG_CONS_KI: cfg_next.cons_ki = cfg_wdata;
                gspid_pkg::REG_CONS_KD: cfg_next.cons_kd = cfg_wdata;
                gspid_pkg::REG_AGG_KP:  cfg_next.agg_kp  = cfg_wdata;
                gspid_pkg::REG_AGG_KI:  cfg_next.agg_ki  = cfg_wdata;
                gspid_pkg::REG_AGG_KD:  cfg_next.agg_kd  = cfg_wdata;
                gspid_pkg::REG_LOWER:
                    cfg_next.out_lower = cfg_wdata[gspid_pkg::SIG_W-1:0];
                gspid_pkg::REG_UPPER:
                    cfg_next.out_upper = cfg_wdata[gspid_pkg::SIG_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cons_kp   <= gspid_pkg::RST_CONS_KP;
            cfg_reg.cons_ki   <= gspid_pkg::RST_CONS_KI;
            cfg_reg.cons_kd   <= gspid_pkg::RST_CONS_KD;
            cfg_reg.agg_kp    <= gspid_pkg::RST_AGG_KP;
            cfg_reg.agg_ki    <= gspid_pkg::RST_AGG_KI;
            cfg_reg.agg_kd    <= gspid_pkg::RST_AGG_KD;
            cfg_reg.out_lower <= gspid_pkg::RST_LOWER;
            cfg_reg.out_upper <= gspid_pkg::RST_UPPER;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/gspid_gain_mul.sv -----
// Gain multiply: signed(+/-gain) * value, floor-shifted right by FRAC_W.
// Depends on gspid_pkg.
module gspid_gain_mul (
    input  logic        [gspid_pkg::GAIN_W-1:0] gain,
    input  logic signed [gspid_pkg::ERR_W-1:0]  value,
    output logic signed [gspid_pkg::TERM_W-1:0] term
);

    logic signed [gspid_pkg::PROD_W-1:0] prod;
    logic signed [gspid_pkg::PROD_W-1:0] prod_dir;

    assign prod     = $signed({1'b0, gain}) * value;
    assign prod_dir = gspid_pkg::REVERSE_ACTION ? -prod : prod;
    // dropping the low bits of a two's complement value rounds toward minus infinity
    assign term     = prod_dir[gspid_pkg::PROD_W-1:gspid_pkg::FRAC_W];

endmodule

// ----- design/gspid_core.sv -----
// Control law and controller state: gain selection, integral, drive, clamps.
// Depends on gspid_pkg, gspid_gain_mul and the assertion macro header.
`include "gain_scheduled_pid_controller_top_macros.svh"

module gspid_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  logic signed [gspid_pkg::SIG_W-1:0]  meas,
    input  logic signed [gspid_pkg::SIG_W-1:0]  tgt,
    input  logic                                auto_req,
    input  gspid_pkg::cfg_t                     cfg,
    output gspid_pkg::result_t                  res
);

    localparam int SIG_W  = gspid_pkg::SIG_W;
    localparam int ERR_W  = gspid_pkg::ERR_W;
    localparam int TERM_W = gspid_pkg::TERM_W;
    localparam int SUM_W  = gspid_pkg::SUM_W;

    function automatic logic [SIG_W-1:0] clamp_sig(
        input logic signed [SUM_W-1:0] x,
        input logic signed [SIG_W-1:0] lo,
        input logic signed [SIG_W-1:0] hi
    );
        logic [SIG_W-1:0] r;
        // when the limits are inverted, a value above the upper bound gets the upper bound and any other gets the lower
        if (x > hi)      r = hi;
        else if (x < lo) r = lo;
        else             r = x[SIG_W-1:0];
        return r;
    endfunction

    logic signed [SIG_W-1:0] integral_reg, integral_next;
    logic signed [SIG_W-1:0] last_meas_reg, last_meas_next;
    logic signed [SIG_W-1:0] held_drive_reg, held_drive_next;
    logic                    was_auto_reg, was_auto_next;

    logic signed [SIG_W-1:0]  lo, hi;
    logic signed [SIG_W-1:0]  last_eff, integ_base, integ_new, drv;
    logic signed [ERR_W-1:0]  err, dmeas;
    logic        [ERR_W-1:0]  mag;
    logic                     agg;
    logic        [gspid_pkg::GAIN_W-1:0] kp, ki, kd;
    logic signed [TERM_W-1:0] kp_term, ki_term, kd_term;
    logic signed [SUM_W-1:0]  integ_sum, drv_sum;

    assign lo = cfg.out_lower;
    assign hi = cfg.out_upper;

    // bumpless start on the first automatic word
    assign last_eff   = was_auto_reg ? last_meas_reg : meas;
    assign integ_base = was_auto_reg ? integral_reg
                                     : clamp_sig(SUM_W'(held_drive_reg), lo, hi);

    assign err   = ERR_W'(tgt) - ERR_W'(meas);
    assign dmeas = ERR_W'(meas) - ERR_W'(last_eff);
    assign mag   = err[ERR_W-1] ? -err : err;
    assign agg   = mag >= ERR_W'(gspid_pkg::GAP_THRESHOLD);

    assign kp = agg ? cfg.agg_kp : cfg.cons_kp;
    assign ki = agg ? cfg.agg_ki : cfg.cons_ki;
    assign kd = agg ? cfg.agg_kd : cfg.cons_kd;

    gspid_gain_mul u_mul_p (.gain(kp), .value(err),   .term(kp_term));
    gspid_gain_mul u_mul_i (.gain(ki), .value(err),   .term(ki_term));
    gspid_gain_mul u_mul_d (.gain(kd), .value(dmeas), .term(kd_term));

    assign integ_sum = SUM_W'(integ_base) + SUM_W'(ki_term);
    assign integ_new = clamp_sig(integ_sum, lo, hi);
    assign drv_sum   = SUM_W'(kp_term) + SUM_W'(integ_new) - SUM_W'(kd_term);
    assign drv       = clamp_sig(drv_sum, lo, hi);

    always_comb begin
        integral_next   = integral_reg;
        last_meas_next  = last_meas_reg;
        held_drive_next = held_drive_reg;
        was_auto_next   = was_auto_reg;
        if (fire) begin
            if (auto_req) begin
                integral_next   = integ_new;
                last_meas_next  = meas;
                held_drive_next = drv;
                was_auto_next   = 1'b1;
            end else begin
                was_auto_next   = 1'b0;
            end
        end
    end

    always_comb begin
        res.drive      = auto_req ? drv : held_drive_reg;
        res.updated    = auto_req;
        res.aggressive = auto_req & agg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg   <= '0;
            last_meas_reg  <= '0;
            held_drive_reg <= '0;
            was_auto_reg   <= 1'b0;
        end else begin
            integral_reg   <= integral_next;
            last_meas_reg  <= last_meas_next;
            held_drive_reg <= held_drive_next;
            was_auto_reg   <= was_auto_next;
        end
    end

    `GSPID_ASSERT_NEXT(a_auto_sets_mode, fire && auto_req, was_auto_reg, "automatic word did not set mode")
    `GSPID_ASSERT_NEXT(a_manual_holds, fire && !auto_req, $stable(held_drive_reg) && $stable(integral_reg), "manual word changed held state")
    `GSPID_ASSERT_NOW(a_drive_in_limits, fire && auto_req && (lo <= hi), (drv >= lo) && (drv <= hi) && (integ_new >= lo) && (integ_new <= hi), "drive or integral outside limits")

endmodule

// ----- design/gain_scheduled_pid_controller_top.sv -----
// An accepted word is held in the input registers and its result is registered onto m_tdata.
// Throughput: one word per cycle unless m_tready stalls the output; the integral,
// last measurement and held drive a word leaves are registered as it fires, ready for the following word.
// Reset: aresetn, synchronous, active low; clears handshake and controller state
// (manual mode, zero integral and drive) and loads the default gains and limits.
module gain_scheduled_pid_controller_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gspid_pkg::S_DATA_W-1:0]       s_tdata,   // [23:0] measurement, [47:24] target
    input  logic [0:0]                           s_tuser,   // [0] automatic_req
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gspid_pkg::M_DATA_W-1:0]       m_tdata,   // [23:0] drive
    output logic [1:0]                           m_tuser,   // [0] updated, [1] aggressive
    // configuration
    input  logic                                 cfg_we,
    input  logic [gspid_pkg::IDX_W-1:0]          cfg_index,
    input  logic [gspid_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int SIG_W = gspid_pkg::SIG_W;

    gspid_pkg::cfg_t    cfg;
    gspid_pkg::result_t res;

    logic                    in_valid_reg, in_valid_next;
    logic signed [SIG_W-1:0] meas_reg, meas_next;
    logic signed [SIG_W-1:0] tgt_reg, tgt_next;
    logic                    auto_reg, auto_next;
    logic                    out_valid_reg, out_valid_next;
    gspid_pkg::result_t      out_reg, out_next;

    logic s_fire, out_free, fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        meas_next     = meas_reg;
        tgt_next      = tgt_reg;
        auto_next     = auto_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
            meas_next     = s_tdata[SIG_W-1:0];
            tgt_next      = s_tdata[2*SIG_W-1:SIG_W];
            auto_next     = s_tuser[0];
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (fire) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        meas_reg <= meas_next;
        tgt_reg  <= tgt_next;
        auto_reg <= auto_next;
        out_reg  <= out_next;
    end

    gspid_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gspid_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .meas     (meas_reg),
        .tgt      (tgt_reg),
        .auto_req (auto_reg),
        .cfg      (cfg),
        .res      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.drive;
    assign m_tuser  = {out_reg.aggressive, out_reg.updated};

endmodule
